// File: hw/rtl/glyph_quad_layout_assert.svh
// ----------------------------------------------------------------------------
// glyph_quad_layout assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_LAYOUT_ASSERT_SVH
`define GLYPH_QUAD_LAYOUT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GQL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph_quad_layout assertion failed");

// Next-cycle implication.
`define GQL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph_quad_layout assertion failed");

`else

`define GQL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GQL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/gql_pkg.sv
// ----------------------------------------------------------------------------
// gql_pkg
// Shared types, constants and helpers of the glyph quad layout block.
// ----------------------------------------------------------------------------
package gql_pkg;

  localparam int GQL_GLYPH_ENTRIES = 256;
  localparam int GQL_TAB_SPACES    = 4;
  // Depth of the queue between front and back; power of two.
  localparam int GQL_QUEUE_DEPTH   = 2;

  localparam int POS_W  = 24;
  // Wide enough for pen + offset + height without overflow.
  localparam int WIDE_W = 27;

  localparam logic [14:0] LINE_HEIGHT_RESET = 15'd1024;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LAYOUT = 1'b1;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_BL = 2'd1;
  localparam logic [1:0] CORNER_TR = 2'd2;
  localparam logic [1:0] CORNER_BR = 2'd3;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         char_code;
    logic               start_of_text;
    logic signed [15:0] load_advance_x;
    logic signed [15:0] load_bearing_x;
    logic signed [15:0] load_offset_y;
    logic [14:0]        load_width;
    logic [14:0]        load_height;
    logic [15:0]        load_tex_left;
    logic [15:0]        load_tex_bottom;
    logic [15:0]        load_tex_right;
    logic [15:0]        load_tex_top;
  } gql_in_t;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [1:0]         corner;
    logic [15:0]        quad_number;
    logic               last_corner;
  } gql_out_t;

  // One glyph table entry.
  typedef struct packed {
    logic signed [15:0] net;
    logic signed [15:0] offy;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [15:0]        tex_left;
    logic [15:0]        tex_bottom;
    logic [15:0]        tex_right;
    logic [15:0]        tex_top;
  } glyph_t;

  // One finished quad, waiting for corner emission.
  typedef struct packed {
    pos_t        x_left;
    pos_t        x_right;
    pos_t        y_top;
    pos_t        y_bottom;
    logic [15:0] tex_left;
    logic [15:0] tex_bottom;
    logic [15:0] tex_right;
    logic [15:0] tex_top;
    logic [15:0] quad_number;
  } quad_t;

  // Clamp a wide signed value to the 24 bit pen range.
  function automatic pos_t sat_pos(input wide_t v);
    logic [WIDE_W-POS_W:0] upper;
    upper = v[WIDE_W-1:POS_W-1];
    if ((&upper) || !(|upper)) begin
      return v[POS_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: hw/rtl/gql_queue.sv
// ----------------------------------------------------------------------------
// gql_queue
// Small FIFO of finished quads between the layout front and vertex back.
// ----------------------------------------------------------------------------
module gql_queue import gql_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  quad_t wr_data,
  output logic  q_full,
  input  logic  rd_en,
  output quad_t rd_data,
  output logic  q_empty
);

  localparam int PTR_W = (GQL_QUEUE_DEPTH > 1) ? $clog2(GQL_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(GQL_QUEUE_DEPTH + 1);

  quad_t            slots [GQL_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = (count == CNT_W'(GQL_QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/gql_front.sv
// ----------------------------------------------------------------------------
// gql_front
// Accepts items, keeps the glyph table, moves the pen and builds quads.
// ----------------------------------------------------------------------------
module gql_front import gql_pkg::*; #(
  parameter int GLYPH_ENTRIES = GQL_GLYPH_ENTRIES,
  parameter int TAB_SPACES    = GQL_TAB_SPACES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  gql_in_t     item,
  input  logic        cfg_valid,
  input  logic [14:0] cfg_data,
  output logic        q_push,
  output quad_t       q_rec,
  input  logic        q_full
);

  localparam int IDX_W = $clog2(GLYPH_ENTRIES);

  typedef enum logic [2:0] {
    K_NEWLINE,
    K_RETURN,
    K_SPACE,
    K_TAB,
    K_GLYPH
  } kind_t;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] idx;
  kind_t            kind_in;
  logic signed [16:0] net_diff;
  logic signed [15:0] load_net;
  wide_t            load_net_w;
  glyph_t           load_glyph;

  glyph_t           table_mem [GLYPH_ENTRIES];
  glyph_t           rd_glyph;

  wide_t            space_net;
  wide_t            space_tab;
  logic [14:0]      line_height;

  logic             s1_valid;
  kind_t            s1_kind;
  logic             s1_sot;
  logic             s1_in_range;
  logic             s1_stall;
  logic             s1_fire;

  pos_t             pen_x;
  pos_t             pen_y;
  logic [15:0]      quad_count;
  pos_t             pen_x_next;
  pos_t             pen_y_next;
  logic [15:0]      quad_count_next;

  glyph_t           g;
  pos_t             base_x;
  pos_t             base_y;
  logic [15:0]      base_q;
  wide_t            bx;
  wide_t            by;

  assign accept   = push && !full;
  assign in_range = {1'b0, item.char_code} < 9'(GLYPH_ENTRIES);
  assign idx      = item.char_code[IDX_W-1:0];

  always_comb begin
    unique case (item.char_code)
      CH_NEWLINE: kind_in = K_NEWLINE;
      CH_RETURN:  kind_in = K_RETURN;
      CH_SPACE:   kind_in = K_SPACE;
      CH_TAB:     kind_in = K_TAB;
      default:    kind_in = K_GLYPH;
    endcase
  end

  // Net advance, clamped to 16 bit signed.
  assign net_diff = 17'(item.load_advance_x) - 17'(item.load_bearing_x);
  always_comb begin
    if (net_diff[16] == net_diff[15]) begin
      load_net = net_diff[15:0];
    end else if (net_diff[16]) begin
      load_net = 16'sh8000;
    end else begin
      load_net = 16'sh7fff;
    end
  end
  assign load_net_w = WIDE_W'(load_net);

  always_comb begin
    load_glyph.net        = load_net;
    load_glyph.offy       = item.load_offset_y;
    load_glyph.width      = item.load_width;
    load_glyph.height     = item.load_height;
    load_glyph.tex_left   = item.load_tex_left;
    load_glyph.tex_bottom = item.load_tex_bottom;
    load_glyph.tex_right  = item.load_tex_right;
    load_glyph.tex_top    = item.load_tex_top;
  end

  // Single port table: a load writes, a layout reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (item.cmd == CMD_LOAD) begin
        if (in_range) begin
          table_mem[idx] <= load_glyph;
        end
      end else begin
        rd_glyph <= table_mem[idx];
      end
    end
  end

  // Shadow of the space entry's advance, and the tab step derived from it.
  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_LOAD && item.char_code == CH_SPACE) begin
      space_net <= load_net_w;
      space_tab <= WIDE_W'(load_net_w * TAB_SPACES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_height <= LINE_HEIGHT_RESET;
    end else if (cfg_valid) begin
      line_height <= cfg_data;
    end
  end

  assign s1_stall = s1_valid && (s1_kind == K_GLYPH) && q_full;
  assign s1_fire  = s1_valid && !s1_stall;
  assign full     = s1_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid <= accept && (item.cmd == CMD_LAYOUT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= kind_in;
      s1_sot      <= item.start_of_text;
      s1_in_range <= in_range;
    end
  end

  assign g      = s1_in_range ? rd_glyph : '0;
  assign base_x = s1_sot ? '0 : pen_x;
  assign base_y = s1_sot ? '0 : pen_y;
  assign base_q = s1_sot ? '0 : quad_count;
  assign bx     = WIDE_W'(base_x);
  assign by     = WIDE_W'(base_y);

  always_comb begin
    pen_x_next      = base_x;
    pen_y_next      = base_y;
    quad_count_next = base_q;
    unique case (s1_kind)
      K_NEWLINE: begin
        pen_y_next = sat_pos(by - WIDE_W'(line_height));
        pen_x_next = '0;
      end
      K_RETURN: begin
        pen_x_next = '0;
      end
      K_SPACE: begin
        pen_x_next = sat_pos(bx + space_net);
      end
      K_TAB: begin
        pen_x_next = sat_pos(bx + space_tab);
      end
      K_GLYPH: begin
        pen_x_next      = sat_pos(bx + WIDE_W'(g.net));
        quad_count_next = base_q + 16'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x      <= '0;
      pen_y      <= '0;
      quad_count <= '0;
    end else if (s1_fire) begin
      pen_x      <= pen_x_next;
      pen_y      <= pen_y_next;
      quad_count <= quad_count_next;
    end
  end

  assign q_push = s1_fire && (s1_kind == K_GLYPH);

  always_comb begin
    q_rec.x_left      = base_x;
    q_rec.x_right     = sat_pos(bx + WIDE_W'(g.width));
    q_rec.y_bottom    = sat_pos(by + WIDE_W'(g.offy));
    q_rec.y_top       = sat_pos(by + WIDE_W'(g.offy) + WIDE_W'(g.height));
    q_rec.tex_left    = g.tex_left;
    q_rec.tex_bottom  = g.tex_bottom;
    q_rec.tex_right   = g.tex_right;
    q_rec.tex_top     = g.tex_top;
    q_rec.quad_number = base_q;
  end

endmodule

// File: hw/rtl/gql_back.sv
// ----------------------------------------------------------------------------
// gql_back
// Holds one quad and hands out its four corners in order.
// ----------------------------------------------------------------------------
module gql_back import gql_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  quad_t    q_rec,
  output logic     q_pop,
  output logic     empty,
  input  logic     pop,
  output gql_out_t result
);

  logic       busy;
  logic [1:0] corner;
  quad_t      cur;
  logic       done;

  assign done  = busy && pop && (corner == CORNER_BR);
  assign q_pop = !q_empty && (!busy || done);
  assign empty = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      corner <= CORNER_TL;
    end else if (q_pop) begin
      busy   <= 1'b1;
      corner <= CORNER_TL;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && pop) begin
      corner <= corner + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rec;
    end
  end

  // Corner bit 1 picks the right edge, bit 0 the bottom edge.
  always_comb begin
    result.vertex_x    = corner[1] ? cur.x_right : cur.x_left;
    result.vertex_y    = corner[0] ? cur.y_bottom : cur.y_top;
    result.tex_u       = corner[1] ? cur.tex_right : cur.tex_left;
    result.tex_v       = corner[0] ? cur.tex_bottom : cur.tex_top;
    result.corner      = corner;
    result.quad_number = cur.quad_number;
    result.last_corner = (corner == CORNER_BR);
  end

endmodule

// File: hw/rtl/glyph_quad_layout.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Bitmap font text layout: glyph table, pen, and textured quad corners.
// Input channel (push/full): cmd 0 writes a glyph table entry, cmd 1 lays out
// one character. An item is taken at an edge with push high and full low.
// Result channel (empty/pop): one textured corner per item, four per visible
// glyph, oldest on the ports while empty is low, taken when pop is high.
// Config channel (cfg_valid/cfg_ready): line_height, always ready; write it
// only while the block is idle.
// A visible glyph passes the s1 register, the quad queue and the back's
// quad register before its first corner shows. Loads and control characters
// emit nothing. Throughput is one item per cycle while full is low; each
// visible glyph holds the single result port for four pops, so glyphs drain
// at four pops each; a two-entry quad queue decouples front from back.
// A stalled receiver fills the quad queue, then full rises and input stops.
// Reset clears pen, quad count, line_height (to 1024) and all valid state;
// the glyph table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`include "glyph_quad_layout_assert.svh"

module glyph_quad_layout import gql_pkg::*; #(
  parameter int GLYPH_ENTRIES = GQL_GLYPH_ENTRIES,
  parameter int TAB_SPACES    = GQL_TAB_SPACES
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        push,
  output logic        full,
  input  gql_in_t     item,
  // result channel
  output logic        empty,
  input  logic        pop,
  output gql_out_t    result,
  // line_height write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  logic  q_wr;
  logic  q_rd;
  logic  q_full;
  logic  q_empty;
  quad_t q_in;
  quad_t q_out;

  // Always take config writes; they land in the line_height register.
  assign cfg_ready = 1'b1;

  // Front: accept, classify, table access, pen arithmetic.
  gql_front #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES),
    .TAB_SPACES    (TAB_SPACES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (q_wr),
    .q_rec     (q_in),
    .q_full    (q_full)
  );

  // Hold finished quads so the front keeps going while corners drain.
  gql_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_in),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_out),
    .q_empty (q_empty)
  );

  // Back: advance through the four corners of the current quad.
  gql_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rec   (q_out),
    .q_pop   (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // Input stalls only behind a full quad queue.
  `GQL_ASSERT_IMPLY(a_full_needs_queue_full, clk, rst, full, q_full)
  // Within a quad, corners advance by one and the quad number holds.
  `GQL_ASSERT_NEXT(a_corner_advance, clk, rst, (pop && !empty && !result.last_corner), (!empty && result.corner == $past(result.corner) + 2'd1 && result.quad_number == $past(result.quad_number)))
  // After the last corner, a following quad starts at top-left.
  `GQL_ASSERT_NEXT(a_next_quad_top_left, clk, rst, (pop && !empty && result.last_corner), (empty || result.corner == CORNER_TL))

endmodule

// File: tb/glyph_layout_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_layout_checker
// Watches the item, result and line_height channels of glyph_quad_layout,
// keeps its own glyph table and pen, predicts the corners of every accepted
// character and compares them in order with the corners the block pops.
// ----------------------------------------------------------------------------
module glyph_layout_checker import gql_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  gql_in_t     item,
  input  logic        empty,
  input  logic        pop,
  input  gql_out_t    result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [14:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          corners_checked
);

  localparam longint PEN_MAX = 64'sd8388607;
  localparam longint PEN_MIN = -64'sd8388608;
  localparam longint NET_MAX = 64'sd32767;
  localparam longint NET_MIN = -64'sd32768;

  glyph_t      font [GQL_GLYPH_ENTRIES];
  pos_t        pen_x;
  pos_t        pen_y;
  logic [15:0] quad_count;
  logic [14:0] line_height;
  gql_out_t    expected_corners [$];

  function automatic pos_t clamp_pen(input longint v);
    if (v > PEN_MAX) begin
      return pos_t'(PEN_MAX);
    end else if (v < PEN_MIN) begin
      return pos_t'(PEN_MIN);
    end
    return pos_t'(v);
  endfunction

  function automatic gql_out_t make_corner(input logic [1:0] crn, input pos_t x, input pos_t y,
                                           input logic [15:0] u, input logic [15:0] v);
    gql_out_t c;
    c.vertex_x    = x;
    c.vertex_y    = y;
    c.tex_u       = u;
    c.tex_v       = v;
    c.corner      = crn;
    c.quad_number = quad_count;
    c.last_corner = (crn == CORNER_BR);
    return c;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic load_glyph(input gql_in_t it);
    longint net;
    net = longint'($signed(it.load_advance_x)) - longint'($signed(it.load_bearing_x));
    if (net > NET_MAX) net = NET_MAX;
    if (net < NET_MIN) net = NET_MIN;
    if (it.char_code < GQL_GLYPH_ENTRIES) begin
      font[it.char_code].net        = net[15:0];
      font[it.char_code].offy       = it.load_offset_y;
      font[it.char_code].width      = it.load_width;
      font[it.char_code].height     = it.load_height;
      font[it.char_code].tex_left   = it.load_tex_left;
      font[it.char_code].tex_bottom = it.load_tex_bottom;
      font[it.char_code].tex_right  = it.load_tex_right;
      font[it.char_code].tex_top    = it.load_tex_top;
    end
  endtask

  task automatic place_char(input gql_in_t it);
    glyph_t g;
    longint spc;
    pos_t   xl, xr, yt, yb;
    if (it.start_of_text) begin
      pen_x      = '0;
      pen_y      = '0;
      quad_count = '0;
    end
    spc = longint'($signed(font[CH_SPACE].net));
    case (it.char_code)
      CH_NEWLINE: begin
        pen_y = clamp_pen(longint'(pen_y) - longint'(line_height));
        pen_x = '0;
      end
      CH_RETURN: pen_x = '0;
      CH_SPACE:  pen_x = clamp_pen(longint'(pen_x) + spc);
      CH_TAB:    pen_x = clamp_pen(longint'(pen_x) + spc * GQL_TAB_SPACES);
      default: begin
        // codes past the table see all-zero metrics
        g  = (it.char_code < GQL_GLYPH_ENTRIES) ? font[it.char_code] : '0;
        xl = pen_x;
        xr = clamp_pen(longint'(pen_x) + longint'(g.width));
        yb = clamp_pen(longint'(pen_y) + longint'(g.offy));
        yt = clamp_pen(longint'(pen_y) + longint'(g.offy) + longint'(g.height));
        expected_corners.push_back(make_corner(CORNER_TL, xl, yt, g.tex_left, g.tex_top));
        expected_corners.push_back(make_corner(CORNER_BL, xl, yb, g.tex_left, g.tex_bottom));
        expected_corners.push_back(make_corner(CORNER_TR, xr, yt, g.tex_right, g.tex_top));
        expected_corners.push_back(make_corner(CORNER_BR, xr, yb, g.tex_right, g.tex_bottom));
        pen_x      = clamp_pen(longint'(pen_x) + longint'(g.net));
        quad_count = quad_count + 16'd1;
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic [23:0] got,
                               input logic [23:0] want, input gql_out_t slot);
    if (got !== want) begin
      report($sformatf("quad %0d corner %0d %s: got %0h, expected %0h",
                       slot.quad_number, slot.corner, field, got, want));
    end
  endtask

  task automatic check_corner(input gql_out_t got);
    gql_out_t want;
    if (expected_corners.size() == 0) begin
      report($sformatf("corner %0d of quad %0d popped with nothing expected",
                       got.corner, got.quad_number));
    end else begin
      want = expected_corners.pop_front();
      corners_checked++;
      compare_field("vertex_x", got.vertex_x, want.vertex_x, want);
      compare_field("vertex_y", got.vertex_y, want.vertex_y, want);
      compare_field("tex_u", 24'(got.tex_u), 24'(want.tex_u), want);
      compare_field("tex_v", 24'(got.tex_v), 24'(want.tex_v), want);
      compare_field("corner", 24'(got.corner), 24'(want.corner), want);
      compare_field("quad_number", 24'(got.quad_number), 24'(want.quad_number), want);
      compare_field("last_corner", 24'(got.last_corner), 24'(want.last_corner), want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pen_x       = '0;
      pen_y       = '0;
      quad_count  = '0;
      line_height = LINE_HEIGHT_RESET;
      expected_corners.delete();
    end else begin
      if (cfg_valid && cfg_ready) line_height = cfg_data;
      if (pop && !empty) check_corner(result);
      if (push && !full) begin
        if (item.cmd == CMD_LOAD) begin
          load_glyph(item);
        end else begin
          place_char(item);
        end
      end
    end
    pending <= expected_corners.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for glyph_quad_layout. Loads glyph metrics, lays out
// directed and random texts under several line heights, drives the pen into
// both horizontal clamps, and lets the checker compare every popped corner.
// ----------------------------------------------------------------------------
module tb import gql_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 1000;
  // leave margin for items still in flight after the last corner
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_WAIT       = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  gql_in_t     item = '0;
  logic        empty;
  logic        pop = 1'b0;
  gql_out_t    result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [14:0] cfg_data = '0;

  int mismatches;
  int pending;
  int corners_checked;

  // table entries that hold data; every quad-drawing code sent is one of these
  bit loaded [GQL_GLYPH_ENTRIES];
  int items_sent  = 0;
  int loads_sent  = 0;
  int lh_writes   = 0;
  int idle_cycles = 0;
  int calm_tx     = 0;
  int calm_rx     = 0;

  glyph_quad_layout dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  glyph_layout_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .item            (item),
    .empty           (empty),
    .pop             (pop),
    .result          (result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .corners_checked (corners_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // End the run if no item moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Draw the wait before the next item: mostly random, sometimes a calm
  // stretch with no waits at all.
  task automatic draw_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
      cycles = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                           : $urandom_range(0, MAX_WAIT);
    end
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random content in every field; callers fix what matters.
  function automatic gql_in_t random_payload();
    gql_in_t it;
    it.cmd             = 1'($urandom_range(0, 1));
    it.char_code       = 8'($urandom_range(0, 255));
    it.start_of_text   = 1'($urandom_range(0, 1));
    it.load_advance_x  = pick16();
    it.load_bearing_x  = pick16();
    it.load_offset_y   = pick16();
    it.load_width      = 15'(pick16());
    it.load_height     = 15'(pick16());
    it.load_tex_left   = pick16();
    it.load_tex_bottom = pick16();
    it.load_tex_right  = pick16();
    it.load_tex_top    = pick16();
    return it;
  endfunction

  function automatic gql_in_t random_load(input logic [7:0] code);
    gql_in_t it;
    it           = random_payload();
    it.cmd       = CMD_LOAD;
    it.char_code = code;
    return it;
  endfunction

  function automatic gql_in_t glyph_load(input logic [7:0] code, input logic [15:0] adv,
                                         input logic [15:0] bear, input logic [15:0] offy,
                                         input logic [14:0] w, input logic [14:0] h,
                                         input logic [15:0] tex);
    gql_in_t it;
    it                 = random_load(code);
    it.load_advance_x  = adv;
    it.load_bearing_x  = bear;
    it.load_offset_y   = offy;
    it.load_width      = w;
    it.load_height     = h;
    it.load_tex_left   = tex;
    it.load_tex_bottom = tex;
    it.load_tex_right  = tex;
    it.load_tex_top    = tex;
    return it;
  endfunction

  // Load fields ride along as noise; the block ignores them on layout.
  function automatic gql_in_t make_layout(input logic [7:0] code, input logic sot);
    gql_in_t it;
    it               = random_payload();
    it.cmd           = CMD_LAYOUT;
    it.char_code     = code;
    it.start_of_text = sot;
    return it;
  endfunction

  // Any loaded code that draws a quad.
  function automatic logic [7:0] pick_glyph();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (!loaded[c] || c == CH_TAB || c == CH_NEWLINE || c == CH_RETURN ||
               c == CH_SPACE);
    return c;
  endfunction

  function automatic logic [7:0] text_code();
    case ($urandom_range(0, 9))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NEWLINE;
      3: return CH_RETURN;
      default: return pick_glyph();
    endcase
  endfunction

  // Offer one item after a random wait and hold it until it is taken.
  // Drop push only when a wait follows, so it never toggles within a step.
  task automatic send(input gql_in_t it);
    int gap;
    draw_wait(calm_tx, gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (it.cmd == CMD_LOAD) begin
      loaded[it.char_code] = 1'b1;
      loads_sent++;
    end
    items_sent++;
  endtask

  // Hold the sender until every expected corner is out, then let any
  // control character still in flight finish.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_height(input logic [14:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lh_writes++;
  endtask

  // Mostly texts that start with start_of_text, mixed with table reloads and
  // stray characters that may restart the pen mid-text.
  task automatic random_phase(input int n);
    int first;
    int len;
    int r;
    first = items_sent;
    while (items_sent - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send(random_load(8'($urandom_range(0, 255))));
      end else if (r < 30) begin
        send(make_layout(text_code(), 1'($urandom_range(0, 1))));
      end else begin
        len = $urandom_range(2, 12);
        for (int k = 0; k < len; k++) send(make_layout(text_code(), k == 0));
      end
    end
  endtask

  // Push the pen into a horizontal clamp: an extreme space advance and a
  // long row of tabs, then glyphs drawn against the edge.
  task automatic runaway_line(input logic [15:0] adv);
    gql_in_t sp;
    sp                = random_load(CH_SPACE);
    sp.load_advance_x = adv;
    sp.load_bearing_x = '0;
    send(sp);
    send(make_layout(pick_glyph(), 1'b1));
    repeat (68) send(make_layout(CH_TAB, 1'b0));
    repeat (2) send(make_layout(pick_glyph(), 1'b0));
  endtask

  // Receiver: wait a random number of cycles before each pop.
  initial begin
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      draw_wait(calm_rx, gap);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: saturated net advances both ways, extreme metrics, code
    // zero, top code, every control character, restart mid-text.
    send(glyph_load(CH_SPACE, 16'd640, 16'd64, 16'h0040, 15'd320, 15'd512, 16'h1234));
    send(glyph_load(8'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF));
    send(glyph_load(8'd255, 16'h8000, 16'h7FFF, 16'h8000, 15'h0000, 15'h0000, 16'h0000));
    send(random_load(8'd65));
    send(random_load(8'd128));
    send(make_layout(8'd0, 1'b1));
    send(make_layout(8'd255, 1'b0));
    send(make_layout(8'd65, 1'b0));
    send(make_layout(CH_SPACE, 1'b0));
    send(make_layout(CH_TAB, 1'b0));
    send(make_layout(CH_NEWLINE, 1'b0));
    send(make_layout(8'd128, 1'b0));
    send(make_layout(CH_RETURN, 1'b0));
    send(make_layout(8'd0, 1'b0));
    send(make_layout(CH_NEWLINE, 1'b0));
    send(make_layout(CH_NEWLINE, 1'b0));
    send(make_layout(8'd255, 1'b1));
    send(make_layout(CH_TAB, 1'b0));
    send(make_layout(8'd65, 1'b0));

    // Random texts at the reset line height.
    random_phase(60);

    // Zero line height: newlines only return to column zero.
    write_line_height(15'h0000);
    random_phase(30);

    // Largest line height: step the pen down several lines and draw
    // glyphs far below the baseline.
    write_line_height(15'h7FFF);
    send(make_layout(pick_glyph(), 1'b1));
    repeat (8) send(make_layout(CH_NEWLINE, 1'b0));
    repeat (2) send(make_layout(pick_glyph(), 1'b0));
    random_phase(30);

    // Random line height, pen into both horizontal clamps.
    write_line_height(15'($urandom_range(1, 32766)));
    runaway_line(16'h7FFF);
    runaway_line(16'h8000);
    random_phase(36);

    settle();
    $display("Run covered %0d items (%0d table loads) and %0d compared corners,",
             items_sent, loads_sent, corners_checked);
    $display("over %0d line height writes and both horizontal pen clamps.",
             lh_writes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/gql_pkg.sv
hw/rtl/gql_queue.sv
hw/rtl/gql_front.sv
hw/rtl/gql_back.sv
hw/rtl/glyph_quad_layout.sv
tb/glyph_layout_checker.sv
tb/tb.sv
